/* src/lorenz_pkg.sv */
// Shared types, codes and saturation helper for the Lorenz Euler stepper.
`timescale 1ns / 1ps

package lorenz_pkg;

  // Width of the shared multiplier product (33 x 33 signed).
  localparam int PROD_W = 66;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SIGMA     = 2'd0,
    CFG_BETA      = 2'd1,
    CFG_RHO       = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_reg_t;

  // Controller states: idle, one per use of the shared multiplier, and finish.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_DX,
    ST_M_DY,
    ST_M_XY,
    ST_M_BZ,
    ST_I_X,
    ST_I_Y,
    ST_I_Z,
    ST_FIN
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_SIG_YX,
    MUL_X_RZ,
    MUL_X_Y,
    MUL_B_Z,
    MUL_T_DX,
    MUL_T_DY,
    MUL_T_DZ
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     start;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_dx;
    logic     ld_dy;
    logic     ld_t;
    logic     ld_dz;
    logic     upd_x;
    logic     upd_y;
    logic     fin;
  } cmd_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(PROD_W'(32'h7FFF_FFFF))) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -$signed(PROD_W'(33'h0_8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* src/lorenz_in_if.sv */
// Input channel: one step request with its restart flag.
`timescale 1ns / 1ps

interface lorenz_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* src/lorenz_out_if.sv */
// Output channel: the point after one Euler step.
`timescale 1ns / 1ps

interface lorenz_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic signed [31:0] next_z;

  modport source (output valid, output next_x, output next_y, output next_z, input ready);
  modport sink (input valid, input next_x, input next_y, input next_z, output ready);
endinterface

/* src/lorenz_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface lorenz_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/lorenz_ctrl.sv */
// Step sequencer: walks the shared multiplier through the seven products.
`timescale 1ns / 1ps

module lorenz_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lorenz_pkg::cmd_t  cmd
);

  lorenz_pkg::state_t state;
  lorenz_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lorenz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on finish, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == lorenz_pkg::ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = lorenz_pkg::MUL_SIG_YX;
    unique case (state)
      lorenz_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = lorenz_pkg::ST_M_DX;
        end
      end
      lorenz_pkg::ST_M_DX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_SIG_YX;
        state_next  = lorenz_pkg::ST_M_DY;
      end
      lorenz_pkg::ST_M_DY: begin
        cmd.ld_dx   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_X_RZ;
        state_next  = lorenz_pkg::ST_M_XY;
      end
      lorenz_pkg::ST_M_XY: begin
        cmd.ld_dy   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_X_Y;
        state_next  = lorenz_pkg::ST_M_BZ;
      end
      lorenz_pkg::ST_M_BZ: begin
        cmd.ld_t    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_B_Z;
        state_next  = lorenz_pkg::ST_I_X;
      end
      lorenz_pkg::ST_I_X: begin
        cmd.ld_dz   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_T_DX;
        state_next  = lorenz_pkg::ST_I_Y;
      end
      lorenz_pkg::ST_I_Y: begin
        cmd.upd_x   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_T_DY;
        state_next  = lorenz_pkg::ST_I_Z;
      end
      lorenz_pkg::ST_I_Z: begin
        cmd.upd_y   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lorenz_pkg::MUL_T_DZ;
        state_next  = lorenz_pkg::ST_FIN;
      end
      lorenz_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.fin    = 1'b1;
          state_next = lorenz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lorenz_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/lorenz_dp.sv */
// Datapath: point, configuration registers, shared multiplier and saturation.
`timescale 1ns / 1ps

module lorenz_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lorenz_pkg::cmd_t         cmd,
  input  logic                     restart,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  output logic signed [31:0]       next_x,
  output logic signed [31:0]       next_y,
  output logic signed [31:0]       next_z
);

  localparam int PW = lorenz_pkg::PROD_W;
  localparam int TW = PW - FRAC_BITS;
  localparam logic signed [31:0] ONE_FX = 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [31:0] SIGMA_RST = 32'(64'sd10 <<< FRAC_BITS);
  localparam logic signed [31:0] BETA_RST =
    32'(((64'sd26666 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000);
  localparam logic signed [31:0] RHO_RST = 32'(64'sd28 <<< FRAC_BITS);
  localparam logic [24:0] TS_RST = 25'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

  logic signed [31:0] sigma;
  logic signed [31:0] beta;
  logic signed [31:0] rho;
  logic [24:0]        time_step;

  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;
  logic signed [TW-1:0] t;

  logic signed [PW-1:0] prod;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [PW-1:0] sh;
  logic signed [32:0]   ts_op;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma     <= SIGMA_RST;
      beta      <= BETA_RST;
      rho       <= RHO_RST;
      time_step <= TS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lorenz_pkg::CFG_SIGMA:     sigma     <= cfg_data;
        lorenz_pkg::CFG_BETA:      beta      <= cfg_data;
        lorenz_pkg::CFG_RHO:       rho       <= cfg_data;
        lorenz_pkg::CFG_TIME_STEP: time_step <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  assign ts_op = $signed({8'b0, time_step});

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = 33'(sigma);
    mul_b = 33'(point_y) - 33'(point_x);
    unique case (cmd.mul_sel)
      lorenz_pkg::MUL_SIG_YX: begin
        mul_a = 33'(sigma);
        mul_b = 33'(point_y) - 33'(point_x);
      end
      lorenz_pkg::MUL_X_RZ: begin
        mul_a = 33'(point_x);
        mul_b = 33'(rho) - 33'(point_z);
      end
      lorenz_pkg::MUL_X_Y: begin
        mul_a = 33'(point_x);
        mul_b = 33'(point_y);
      end
      lorenz_pkg::MUL_B_Z: begin
        mul_a = 33'(beta);
        mul_b = 33'(point_z);
      end
      lorenz_pkg::MUL_T_DX: begin
        mul_a = ts_op;
        mul_b = 33'(dx);
      end
      lorenz_pkg::MUL_T_DY: begin
        mul_a = ts_op;
        mul_b = 33'(dy);
      end
      lorenz_pkg::MUL_T_DZ: begin
        mul_a = ts_op;
        mul_b = 33'(dz);
      end
      default: ;
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // Floor shift back to the fixed-point scale
  assign sh = prod >>> FRAC_BITS;

  // Derivatives
  always_ff @(posedge clk) begin
    if (cmd.ld_dx) begin
      dx <= lorenz_pkg::sat32(sh);
    end
    if (cmd.ld_dy) begin
      dy <= lorenz_pkg::sat32(sh - PW'(point_y));
    end
    if (cmd.ld_t) begin
      t <= sh[TW-1:0];
    end
    if (cmd.ld_dz) begin
      dz <= lorenz_pkg::sat32(PW'(t) - sh);
    end
  end

  // Point: reload on restart, advance one coordinate per cycle, z waiting while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= ONE_FX;
      point_y <= ONE_FX;
      point_z <= ONE_FX;
    end else begin
      if (cmd.start && restart) begin
        point_x <= ONE_FX;
        point_y <= ONE_FX;
        point_z <= ONE_FX;
      end
      if (cmd.upd_x) begin
        point_x <= lorenz_pkg::sat32(PW'(point_x) + sh);
      end
      if (cmd.upd_y) begin
        point_y <= lorenz_pkg::sat32(PW'(point_y) + sh);
      end
      if (cmd.fin) begin
        point_z <= lorenz_pkg::sat32(PW'(point_z) + sh);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      next_x <= point_x;
      next_y <= point_y;
      next_z <= lorenz_pkg::sat32(PW'(point_z) + sh);
    end
  end

endmodule

/* src/lorenz_euler_step.sv */
// Lorenz oscillator advancing one forward-Euler step per input transfer.
// The result is registered on leaving ST_FIN, once the output register is free.
// Steps do not overlap; the single 33x33 multiplier is used
// seven times per step (four derivative products, three time-step products).
// Reset: point to 1.0, 1.0, 1.0, registers to their defaults, output empty.
// The configuration port is always ready.
`timescale 1ns / 1ps

module lorenz_euler_step #(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  lorenz_in_if.sink    step_in,
  lorenz_out_if.source step_out,
  lorenz_cfg_if.sink   cfg
);

  lorenz_pkg::cmd_t cmd;

  assign cfg.ready = 1'b1;

  lorenz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step_in.valid),
    .in_ready  (step_in.ready),
    .out_valid (step_out.valid),
    .out_ready (step_out.ready),
    .cmd       (cmd)
  );

  lorenz_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .restart   (step_in.restart),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .next_x    (step_out.next_x),
    .next_y    (step_out.next_y),
    .next_z    (step_out.next_z)
  );

endmodule

/* src/lorenz_chk.sv */
// Port-level checks for the Lorenz stepper, bound to the top level.
`timescale 1ns / 1ps

module lorenz_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // After reset the input side is open and no result waits
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("not idle after reset");

  // A step in progress blocks the input side
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input ready right after a transfer");

  // A result never appears the cycle after an input transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_xfer))
    else $error("result appeared too early");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z)))
    else $error("stalled result changed");

endmodule

bind lorenz_euler_step lorenz_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (step_in.valid),
  .in_ready  (step_in.ready),
  .out_valid (step_out.valid),
  .out_ready (step_out.ready),
  .out_x     (step_out.next_x),
  .out_y     (step_out.next_y),
  .out_z     (step_out.next_z)
);

/* sim/lorenz_trajectory_check.sv */
// Monitor, trajectory predictor and result comparison for the Lorenz Euler stepper.
`timescale 1ns / 1ps

module lorenz_trajectory_check #(
  parameter int FRAC_BITS = 24
) (
  input  logic  clk,
  input  logic  rst,
  lorenz_in_if  step_in,
  lorenz_out_if step_out,
  lorenz_cfg_if cfg,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  localparam longint      ONE       = 64'sd1 << FRAC_BITS;
  localparam logic [31:0] SIGMA_RST = 32'(64'sd10 << FRAC_BITS);
  localparam logic [31:0] BETA_RST  = 32'(((64'sd26666 << FRAC_BITS) + 64'sd5000) / 64'sd10000);
  localparam logic [31:0] RHO_RST   = 32'(64'sd28 << FRAC_BITS);
  localparam logic [24:0] DT_RST    = 25'((ONE + 64'sd500) / 64'sd1000);

  logic [31:0] sigma_q;
  logic [31:0] beta_q;
  logic [31:0] rho_q;
  logic [24:0] dt_q;
  point_t      point_q;
  point_t      expected_points[$];
  point_t      want;

  // Drop the fraction bits, rounding toward minus infinity.
  function automatic longint fx_floor(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Advance the point by one forward-Euler step under the current registers.
  function automatic point_t euler_step(point_t p, logic restart);
    longint px, py, pz, sg, bt, rh, ts, dx, dy, dz;
    point_t n;
    if (restart) begin
      px = ONE;
      py = ONE;
      pz = ONE;
    end else begin
      px = longint'($signed(p.x));
      py = longint'($signed(p.y));
      pz = longint'($signed(p.z));
    end
    sg = longint'($signed(sigma_q));
    bt = longint'($signed(beta_q));
    rh = longint'($signed(rho_q));
    ts = longint'(dt_q);
    // All three derivatives come from the point before the step.
    dx = clamp32(fx_floor(sg * (py - px)));
    dy = clamp32(fx_floor(px * (rh - pz)) - py);
    dz = clamp32(fx_floor(px * py) - fx_floor(bt * pz));
    n.x = 32'(clamp32(px + fx_floor(ts * dx)));
    n.y = 32'(clamp32(py + fx_floor(ts * dy)));
    n.z = 32'(clamp32(pz + fx_floor(ts * dz)));
    return n;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sigma_q    = SIGMA_RST;
      beta_q     = BETA_RST;
      rho_q      = RHO_RST;
      dt_q       = DT_RST;
      point_q    = '{x: 32'(ONE), y: 32'(ONE), z: 32'(ONE)};
      fail_count = 0;
      expected_points.delete();
    end else begin
      // Compare each result transfer with the oldest predicted point.
      if (step_out.valid && step_out.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: next_x %0d, next_y %0d, next_z %0d",
                 step_out.next_x, step_out.next_y, step_out.next_z);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("next_x", want.x, step_out.next_x);
          check_field("next_y", want.y, step_out.next_y);
          check_field("next_z", want.z, step_out.next_z);
        end
      end
      // Track register writes.
      if (cfg.valid && cfg.ready) begin
        case (lorenz_pkg::cfg_reg_t'(cfg.index))
          lorenz_pkg::CFG_SIGMA:     sigma_q = cfg.data;
          lorenz_pkg::CFG_BETA:      beta_q  = cfg.data;
          lorenz_pkg::CFG_RHO:       rho_q   = cfg.data;
          lorenz_pkg::CFG_TIME_STEP: dt_q    = cfg.data[24:0];
          default: ;
        endcase
      end
      // Predict the point for each accepted step.
      if (step_in.valid && step_in.ready) begin
        point_q = euler_step(point_q, step_in.restart);
        expected_points.push_back(point_q);
      end
    end
    pending = expected_points.size();
  end

endmodule

/* sim/tb_lorenz_euler_step.sv */
// Top of the Lorenz Euler stepper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lorenz_euler_step;

  localparam int          FRAC_BITS   = 24;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 100;
  localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN     = 32'h8000_0000;
  localparam logic [31:0] DT_MAX      = 32'h01FF_FFFF;
  localparam logic [31:0] FX_ONE      = 32'd1 << FRAC_BITS;
  localparam logic [31:0] SIGMA_DEF   = 32'd10 << FRAC_BITS;
  localparam logic [31:0] BETA_DEF    = 32'(((64'sd26666 << FRAC_BITS) + 64'sd5000) / 64'sd10000);
  localparam logic [31:0] BETA_8_3    = 32'(((64'sd8 << FRAC_BITS) + 64'sd1) / 64'sd3);
  localparam logic [31:0] RHO_DEF     = 32'd28 << FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;

  lorenz_in_if  in_if ();
  lorenz_out_if out_if ();
  lorenz_cfg_if cfg_if ();

  lorenz_euler_step #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .step_in(in_if),
    .step_out(out_if),
    .cfg(cfg_if)
  );

  lorenz_trajectory_check #(.FRAC_BITS(FRAC_BITS)) chk (
    .clk(clk),
    .rst(rst),
    .step_in(in_if),
    .step_out(out_if),
    .cfg(cfg_if),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #5 clk = ~clk;

  // Throttle the result side.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one step after a random gap; valid stays high until the next gap.
  task automatic send_step(bit restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic cfg_write(lorenz_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_params(logic [31:0] sg, logic [31:0] bt, logic [31:0] rh,
                            logic [31:0] ts_word);
    cfg_write(lorenz_pkg::CFG_SIGMA, sg);
    cfg_write(lorenz_pkg::CFG_BETA, bt);
    cfg_write(lorenz_pkg::CFG_RHO, rh);
    cfg_write(lorenz_pkg::CFG_TIME_STEP, ts_word);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until every predicted point has come back, then let the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          kind;
    logic [31:0] dt_word;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = lorenz_pkg::CFG_SIGMA;
    cfg_if.data   = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: continue from the reset point, then restart mid-trajectory.
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b1);
    drain();

    // Extreme gains and the largest time step drive the point onto the rails.
    set_params(S32_MAX, S32_MIN, S32_MAX, DT_MAX);
    send_step(1'b1);
    repeat (5) send_step(1'b0);
    drain();

    // Zero time step holds the point; opposite extremes on the gains.
    set_params(S32_MIN, S32_MAX, S32_MIN, 32'd0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    drain();

    // Time step above one.
    set_params(SIGMA_DEF, BETA_DEF, RHO_DEF, FX_ONE + (FX_ONE >> 1));
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain();

    // Random phases: long trajectories with occasional restarts.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      kind = (ph + ph / 4) % 4;
      case (kind)
        0: set_params(SIGMA_DEF, BETA_8_3, RHO_DEF, $urandom_range(1, 1 << 20));
        1: set_params($urandom, $urandom, $urandom, $urandom);
        2: begin
          case ($urandom_range(0, 3))
            0: dt_word = 32'd0;
            1: dt_word = DT_MAX;
            2: dt_word = FX_ONE;
            default: dt_word = $urandom_range(0, DT_MAX);
          endcase
          set_params(pick_gain(), pick_gain(), pick_gain(), dt_word);
        end
        default: begin
          dt_word = {7'($urandom_range(0, 127)), 25'd0} | $urandom_range(0, DT_MAX);
          set_params(SIGMA_DEF, BETA_DEF, RHO_DEF, dt_word);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_step(i == 0 || $urandom_range(0, 19) == 0);
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
